[hw/rtl/clipped_framebuffer_blitter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the blitter
// Clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_FRAMEBUFFER_BLITTER_ASSERT_SVH
`define CLIPPED_FRAMEBUFFER_BLITTER_ASSERT_SVH

// same-cycle implication
`define CFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cfb_pkg.sv]
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared constants, command types and address helpers of the blitter.
// ----------------------------------------------------------------------------
`default_nettype none
package cfb_pkg;

  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int BUFFER_COUNT = 4;

  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int STORE_DEPTH  = BUFFER_COUNT * FRAME_PIXELS;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int XW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int PW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  localparam logic [2:0] OP_CLEAR      = 3'd0;
  localparam logic [2:0] OP_DRAW_BEGIN = 3'd1;
  localparam logic [2:0] OP_DRAW_PIXEL = 3'd2;
  localparam logic [2:0] OP_READ_BEGIN = 3'd3;
  localparam logic [2:0] OP_READ_REQ   = 3'd4;
  localparam logic [2:0] OP_BLIT       = 3'd5;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_BLIT  = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        dbuf;
    logic [1:0]        sbuf;
    logic [AW-1:0]     addr;
    logic [23:0]       colour;
    logic              hit;
    logic              last;
    logic signed [12:0] rx;
    logic signed [12:0] ry;
    logic [11:0]       rw;
    logic [11:0]       rh;
    logic signed [12:0] sx;
    logic signed [12:0] sy;
  } cmd_t;

  typedef struct packed {
    logic       idle;
    logic [1:0] out_cnt;
  } back_stat_t;

  function automatic logic [AW-1:0] slot(input logic [1:0] b, input logic [YW-1:0] y,
                                         input logic [XW-1:0] x);
    logic [AW-1:0] bb, yy, xx;
    bb = AW'(b);
    yy = AW'(y);
    xx = AW'(x);
    return bb * AW'(FRAME_PIXELS) + yy * AW'(FRAME_WIDTH) + xx;
  endfunction

  function automatic logic buf_ok(input logic [1:0] b);
    return {1'b0, b} < 3'(BUFFER_COUNT);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cfb_queue.sv]
// ----------------------------------------------------------------------------
// cfb_queue
// Four-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module cfb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  cfb_pkg::cmd_t      din,
  input  wire logic          pop,
  output cfb_pkg::cmd_t      dout,
  output logic               full,
  output logic               empty
);
  cfb_pkg::cmd_t mem [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign dout  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push && !full) wp_r <= wp_r + 2'd1;
      if (pop && !empty) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b00, push && !full} - {2'b00, pop && !empty};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/cfb_front.sv]
// ----------------------------------------------------------------------------
// cfb_front
// Takes requests, tracks the open draw or read rectangle, issues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module cfb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [2:0]        in_op,
  input  wire logic [1:0]        in_buffer,
  input  wire logic [1:0]        in_source_buffer,
  input  wire logic signed [12:0] in_rect_x,
  input  wire logic signed [12:0] in_rect_y,
  input  wire logic [11:0]       in_rect_w,
  input  wire logic [11:0]       in_rect_h,
  input  wire logic signed [12:0] in_source_x,
  input  wire logic signed [12:0] in_source_y,
  input  wire logic [7:0]        in_red,
  input  wire logic [7:0]        in_green,
  input  wire logic [7:0]        in_blue,
  input  wire logic              q_full,
  output logic                   q_push,
  output cfb_pkg::cmd_t          q_cmd
);
  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_DRAW = 2'd1;
  localparam logic [1:0] M_READ = 2'd2;

  logic [1:0]  mode_r, buf_r;
  logic [12:0] ox_r, oy_r;
  logic [11:0] w_r, h_r, col_r, row_r;

  logic        acc, last, hit, adv;
  logic [13:0] px, py;
  logic [12:0] col_inc, row_inc;

  assign full    = q_full;
  assign acc     = push && !q_full;
  assign px      = {ox_r[12], ox_r} + {2'b00, col_r};
  assign py      = {oy_r[12], oy_r} + {2'b00, row_r};
  assign col_inc = {1'b0, col_r} + 13'd1;
  assign row_inc = {1'b0, row_r} + 13'd1;
  assign last    = (col_inc >= {1'b0, w_r}) && (row_inc >= {1'b0, h_r});
  assign hit     = cfb_pkg::buf_ok(buf_r) && !px[13] &&
                   (px[12:0] < 13'(cfb_pkg::FRAME_WIDTH)) && !py[13] &&
                   (py[12:0] < 13'(cfb_pkg::FRAME_HEIGHT));

  always_comb begin
    q_cmd.kind   = cfb_pkg::CMD_WRITE;
    q_cmd.dbuf   = in_buffer;
    q_cmd.sbuf   = in_source_buffer;
    q_cmd.addr   = cfb_pkg::slot(buf_r, py[cfb_pkg::YW-1:0], px[cfb_pkg::XW-1:0]);
    q_cmd.colour = {in_red, in_green, in_blue};
    q_cmd.hit    = hit;
    q_cmd.last   = last;
    q_cmd.rx     = in_rect_x;
    q_cmd.ry     = in_rect_y;
    q_cmd.rw     = in_rect_w;
    q_cmd.rh     = in_rect_h;
    q_cmd.sx     = in_source_x;
    q_cmd.sy     = in_source_y;
    q_push       = 1'b0;
    adv          = 1'b0;
    unique case (in_op)
      cfb_pkg::OP_CLEAR: begin
        q_cmd.kind = cfb_pkg::CMD_CLEAR;
        q_push     = acc && cfb_pkg::buf_ok(in_buffer);
      end
      cfb_pkg::OP_DRAW_PIXEL: begin
        q_cmd.kind = cfb_pkg::CMD_WRITE;
        adv        = acc && (mode_r == M_DRAW);
        q_push     = adv && hit;
      end
      cfb_pkg::OP_READ_REQ: begin
        q_cmd.kind = cfb_pkg::CMD_READ;
        adv        = acc && (mode_r == M_READ);
        q_push     = adv;
      end
      cfb_pkg::OP_BLIT: begin
        q_cmd.kind = cfb_pkg::CMD_BLIT;
        q_push     = acc && cfb_pkg::buf_ok(in_buffer) &&
                     (in_rect_w != 12'd0) && (in_rect_h != 12'd0);
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      buf_r  <= 2'd0;
      ox_r   <= 13'd0;
      oy_r   <= 13'd0;
      w_r    <= 12'd0;
      h_r    <= 12'd0;
      col_r  <= 12'd0;
      row_r  <= 12'd0;
    end else if (acc && (in_op == cfb_pkg::OP_DRAW_BEGIN ||
                         in_op == cfb_pkg::OP_READ_BEGIN)) begin
      buf_r <= in_buffer;
      ox_r  <= in_rect_x;
      oy_r  <= in_rect_y;
      w_r   <= in_rect_w;
      h_r   <= in_rect_h;
      col_r <= 12'd0;
      row_r <= 12'd0;
      if (in_rect_w == 12'd0 || in_rect_h == 12'd0) mode_r <= M_IDLE;
      else mode_r <= (in_op == cfb_pkg::OP_DRAW_BEGIN) ? M_DRAW : M_READ;
    end else if (adv) begin
      if (col_inc >= {1'b0, w_r}) begin
        col_r <= 12'd0;
        row_r <= row_inc[11:0];
      end else begin
        col_r <= col_inc[11:0];
      end
      if (last) mode_r <= M_IDLE;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/cfb_back.sv]
// ----------------------------------------------------------------------------
// cfb_back
// Executes commands on the frame store; holds the result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module cfb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  cfb_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_last_pixel,
  output cfb_pkg::back_stat_t stat
);
  localparam int AW = cfb_pkg::AW;
  localparam int XW = cfb_pkg::XW;
  localparam int YW = cfb_pkg::YW;
  localparam int PW = cfb_pkg::PW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_BSET = 3'd2;
  localparam logic [2:0] S_BRD  = 3'd3;
  localparam logic [2:0] S_BDRN = 3'd4;
  localparam logic [2:0] S_BWR  = 3'd5;
  localparam logic [2:0] S_BNXT = 3'd6;

  logic [23:0] store [cfb_pkg::STORE_DEPTH];
  logic [23:0] rowbuf [cfb_pkg::FRAME_WIDTH];

  logic [2:0]  st_r;
  logic [AW-1:0] clr_a_r;
  logic [PW-1:0] clr_n_r;
  logic [23:0] colour_r;
  logic [1:0]  dbuf_r, sbuf_r;
  logic signed [12:0] dx_r, dy_r, sx0_r, sy0_r;
  logic [11:0] w_r, h_r;
  logic signed [14:0] xb_r, xe_r, ye_r, x_r, y_r;
  logic signed [15:0] sx_r, sy_r, sxb_r;

  logic        rp_r, rp_hit_r, rp_last_r;
  logic        tv_r, tok_r;
  logic [XW-1:0] tx_r;
  logic        sv_r;
  logic [AW-1:0] sa_r;
  logic [23:0] rdata_r, trd_r;

  logic [24:0] ofifo [2];
  logic        ohd_r;
  logic [1:0]  ocnt_r;

  logic        we, opop, src_ok, go;
  logic [AW-1:0] wa, ra;
  logic [23:0] wd;
  logic [2:0]  credit;
  logic signed [14:0] xb_c, xe_s, xe_c, yb_c, ye_s, ye_c;

  assign opop   = pop && (ocnt_r != 2'd0);
  assign credit = {1'b0, ocnt_r} + {2'b00, rp_r} - {2'b00, opop};
  assign go     = !q_empty && (q_cmd.kind != cfb_pkg::CMD_READ || credit < 3'd2);
  assign q_pop  = (st_r == S_IDLE) && go;
  assign src_ok = cfb_pkg::buf_ok(sbuf_r) && !sx_r[15] &&
                  (sx_r[14:0] < 15'(cfb_pkg::FRAME_WIDTH)) && !sy_r[15] &&
                  (sy_r[14:0] < 15'(cfb_pkg::FRAME_HEIGHT));

  // clip of the destination rectangle
  assign xb_c = dx_r[12] ? 15'sd0 : $signed({{2{dx_r[12]}}, dx_r});
  assign yb_c = dy_r[12] ? 15'sd0 : $signed({{2{dy_r[12]}}, dy_r});
  assign xe_s = $signed({{2{dx_r[12]}}, dx_r}) + $signed({3'b000, w_r});
  assign ye_s = $signed({{2{dy_r[12]}}, dy_r}) + $signed({3'b000, h_r});
  assign xe_c = (xe_s > $signed(15'(cfb_pkg::FRAME_WIDTH))) ?
                $signed(15'(cfb_pkg::FRAME_WIDTH)) : xe_s;
  assign ye_c = (ye_s > $signed(15'(cfb_pkg::FRAME_HEIGHT))) ?
                $signed(15'(cfb_pkg::FRAME_HEIGHT)) : ye_s;

  always_comb begin
    we = 1'b0;
    wa = q_cmd.addr;
    wd = q_cmd.colour;
    ra = q_cmd.addr;
    if (st_r == S_IDLE && go && q_cmd.kind == cfb_pkg::CMD_WRITE) we = 1'b1;
    if (st_r == S_CLR) begin
      we = 1'b1;
      wa = clr_a_r;
      wd = colour_r;
    end
    if (sv_r) begin
      we = 1'b1;
      wa = sa_r;
      wd = trd_r;
    end
    if (st_r == S_BRD) ra = cfb_pkg::slot(sbuf_r, sy_r[YW-1:0], sx_r[XW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (we) store[wa] <= wd;
    rdata_r <= store[ra];
  end

  always_ff @(posedge clk) begin
    if (tv_r) rowbuf[tx_r] <= tok_r ? rdata_r : 24'd0;
    trd_r <= rowbuf[x_r[XW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rp_r) ofifo[ohd_r + ocnt_r[0]] <= {rp_hit_r ? rdata_r : 24'd0, rp_last_r};
  end

  always_ff @(posedge clk) begin
    tx_r      <= x_r[XW-1:0];
    sa_r      <= cfb_pkg::slot(dbuf_r, y_r[YW-1:0], x_r[XW-1:0]);
    tok_r     <= src_ok;
    rp_hit_r  <= q_cmd.hit;
    rp_last_r <= q_cmd.last;
    if (st_r == S_IDLE && go) begin
      colour_r <= q_cmd.colour;
      clr_a_r  <= cfb_pkg::slot(q_cmd.dbuf, YW'(0), XW'(0));
      clr_n_r  <= PW'(0);
      dbuf_r   <= q_cmd.dbuf;
      sbuf_r   <= q_cmd.sbuf;
      dx_r     <= q_cmd.rx;
      dy_r     <= q_cmd.ry;
      w_r      <= q_cmd.rw;
      h_r      <= q_cmd.rh;
      sx0_r    <= q_cmd.sx;
      sy0_r    <= q_cmd.sy;
    end
    if (st_r == S_CLR) begin
      clr_a_r <= clr_a_r + AW'(1);
      clr_n_r <= clr_n_r + PW'(1);
    end
    unique case (st_r)
      S_BSET: begin
        xb_r  <= xb_c;
        xe_r  <= xe_c;
        ye_r  <= ye_c;
        x_r   <= xb_c;
        y_r   <= yb_c;
        sx_r  <= $signed({{3{sx0_r[12]}}, sx0_r}) + $signed({xb_c[14], xb_c}) -
                 $signed({{3{dx_r[12]}}, dx_r});
        sxb_r <= $signed({{3{sx0_r[12]}}, sx0_r}) + $signed({xb_c[14], xb_c}) -
                 $signed({{3{dx_r[12]}}, dx_r});
        sy_r  <= $signed({{3{sy0_r[12]}}, sy0_r}) + $signed({yb_c[14], yb_c}) -
                 $signed({{3{dy_r[12]}}, dy_r});
      end
      S_BRD, S_BWR: begin
        x_r  <= x_r + 15'sd1;
        sx_r <= sx_r + 16'sd1;
      end
      S_BDRN: begin
        x_r  <= xb_r;
        sx_r <= sxb_r;
      end
      S_BNXT: begin
        x_r  <= xb_r;
        sx_r <= sxb_r;
        y_r  <= y_r + 15'sd1;
        sy_r <= sy_r + 16'sd1;
      end
      default: begin
        x_r <= x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      rp_r   <= 1'b0;
      tv_r   <= 1'b0;
      sv_r   <= 1'b0;
      ohd_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      rp_r   <= (st_r == S_IDLE) && go && (q_cmd.kind == cfb_pkg::CMD_READ);
      tv_r   <= (st_r == S_BRD);
      sv_r   <= (st_r == S_BWR);
      ocnt_r <= ocnt_r + {1'b0, rp_r} - {1'b0, opop};
      if (opop) ohd_r <= ~ohd_r;
      unique case (st_r)
        S_IDLE: begin
          if (go && q_cmd.kind == cfb_pkg::CMD_CLEAR) st_r <= S_CLR;
          if (go && q_cmd.kind == cfb_pkg::CMD_BLIT) st_r <= S_BSET;
        end
        S_CLR:  if (clr_n_r == PW'(cfb_pkg::FRAME_PIXELS - 1)) st_r <= S_IDLE;
        S_BSET: st_r <= (xb_c >= xe_c || yb_c >= ye_c) ? S_IDLE : S_BRD;
        S_BRD:  if (x_r + 15'sd1 == xe_r) st_r <= S_BDRN;
        S_BDRN: st_r <= S_BWR;
        S_BWR:  if (x_r + 15'sd1 == xe_r) st_r <= S_BNXT;
        S_BNXT: st_r <= (y_r + 15'sd1 == ye_r) ? S_IDLE : S_BRD;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign empty          = (ocnt_r == 2'd0);
  assign out_red        = ofifo[ohd_r][24:17];
  assign out_green      = ofifo[ohd_r][16:9];
  assign out_blue       = ofifo[ohd_r][8:1];
  assign out_last_pixel = ofifo[ohd_r][0];
  assign stat.idle      = (st_r == S_IDLE);
  assign stat.out_cnt   = ocnt_r;
endmodule
`default_nettype wire

[hw/rtl/clipped_framebuffer_blitter.sv]
// ----------------------------------------------------------------------------
// clipped_framebuffer_blitter
// 2D engine over four 128x64 RGB frame buffers: clear, draw, read and blit.
// ----------------------------------------------------------------------------
// Requests go in through a queue-style port (push/full) and read pixels come
// out of one (pop/empty). Draw-pixel and read requests stream through the
// back end at one per cycle while no clear or blit occupies it and the
// consumer keeps up; the front classifies requests and a four-entry command
// queue soaks up the long operations. A clear, once taken, occupies the back
// end while it writes a whole buffer, one store write per cycle. In a blit of
// a clipped rectangle, each row is first read from the source into a row
// buffer, then written to the destination, all through the single read and
// single write port of the frame store. While the command queue is full,
// full stays high. The frame store has no reset: pixels never cleared or
// drawn read back as undefined.
// ----------------------------------------------------------------------------
`default_nettype none
module clipped_framebuffer_blitter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [2:0]        in_op,
  input  wire logic [1:0]        in_buffer,
  input  wire logic [1:0]        in_source_buffer,
  input  wire logic signed [12:0] in_rect_x,
  input  wire logic signed [12:0] in_rect_y,
  input  wire logic [11:0]       in_rect_w,
  input  wire logic [11:0]       in_rect_h,
  input  wire logic signed [12:0] in_source_x,
  input  wire logic signed [12:0] in_source_y,
  input  wire logic [7:0]        in_red,
  input  wire logic [7:0]        in_green,
  input  wire logic [7:0]        in_blue,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic                   out_last_pixel
);
`include "clipped_framebuffer_blitter_assert.svh"

  // front -> queue
  logic          q_push, q_full, q_empty, q_pop;
  cfb_pkg::cmd_t q_cmd_in, q_cmd_out;
  cfb_pkg::back_stat_t b_stat;

  cfb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_buffer        (in_buffer),
    .in_source_buffer (in_source_buffer),
    .in_rect_x        (in_rect_x),
    .in_rect_y        (in_rect_y),
    .in_rect_w        (in_rect_w),
    .in_rect_h        (in_rect_h),
    .in_source_x      (in_source_x),
    .in_source_y      (in_source_y),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd_in)
  );

  // decouples request intake from store work
  cfb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_cmd_in),
    .pop   (q_pop),
    .dout  (q_cmd_out),
    .full  (q_full),
    .empty (q_empty)
  );

  // store, row buffer and result queue
  cfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd_out),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last_pixel (out_last_pixel),
    .stat           (b_stat)
  );

  // the front never pushes into a full command queue
  `CFB_ASSERT_IMP(a_q_no_overflow, q_push, !q_full, "command pushed into full queue")
  // read credit keeps the result queue within its two entries
  `CFB_ASSERT_IMP(a_out_bound, 1'b1, b_stat.out_cnt != 2'd3, "result queue overrun")
  // a clear taken by the back end keeps it busy
  `CFB_ASSERT_NXT(a_clear_busy, q_pop && q_cmd_out.kind == cfb_pkg::CMD_CLEAR,
                  !b_stat.idle, "back end idle after clear")

endmodule
`default_nettype wire
